[rtl/tpsc_pkg.sv]
// Package for the two-clip crossfade core: widths, word structs, command codes.
// Used by every module in rtl/; depends on nothing.
package tpsc_pkg;

  localparam int TIME_W = 32;
  localparam int ID_W   = 16;
  localparam int FRAC_W = 16;
  localparam int DVD_W  = TIME_W + FRAC_W;
  localparam int PROD_W = TIME_W + FRAC_W + 1;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [2:0] DSEL_ONE   = 3'd0;
  localparam logic [2:0] DSEL_ALPHA = 3'd1;
  localparam logic [2:0] DSEL_STEP  = 3'd2;
  localparam logic [2:0] DSEL_PA    = 3'd3;
  localparam logic [2:0] DSEL_PB    = 3'd4;

  localparam logic [1:0] MSEL_MIX = 2'd0;
  localparam logic [1:0] MSEL_A   = 2'd1;
  localparam logic [1:0] MSEL_B   = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [15:0] clip_id;
    logic [31:0] clip_length;
    logic [31:0] start_time;
    logic [31:0] fade_length;
    logic [63:0] tag;
    logic [31:0] delta_time;
  } tpsc_in_t;

  typedef struct packed {
    logic        accepted;
    logic        sample_valid;
    logic [1:0]  active_clips;
    logic [15:0] first_id;
    logic [31:0] first_time;
    logic [15:0] second_id;
    logic [31:0] second_time;
    logic [16:0] mix_alpha;
    logic [63:0] first_tag;
    logic [63:0] second_tag;
  } tpsc_out_t;

  typedef struct packed {
    logic       cap;
    logic       div_go;
    logic [2:0] div_sel;
    logic       mul_go;
    logic       mul_fin;
    logic [1:0] mul_sel;
    logic       commit;
  } tpsc_cmd_t;

  typedef struct packed {
    logic       opcode;
    logic [1:0] count;
    logic       div_done;
    logic       out_free;
  } tpsc_stat_t;

endpackage

[rtl/tpsc_div.sv]
// Serial restoring divider, one quotient bit per cycle.
// Depends on tpsc_pkg for widths.
module tpsc_div import tpsc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [TIME_W-1:0] divisor,
  output logic              done,
  output logic [DVD_W-1:0]  quot,
  output logic [TIME_W-1:0] rem
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [TIME_W-1:0] rem_r;
  logic [DVD_W-1:0]  quo_r;
  logic [TIME_W-1:0] dvs_r;
  logic [TIME_W:0]   trial;
  logic [TIME_W:0]   diff;
  logic              ge;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

[rtl/tpsc_ctrl.sv]
// Sequencer for the crossfade core: walks one item through the shared units.
// Depends on tpsc_pkg for command and status structs.
module tpsc_ctrl import tpsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  tpsc_stat_t stat,
  output tpsc_cmd_t  cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DEC    = 4'd1;
  localparam logic [3:0] ST_ONE    = 4'd2;
  localparam logic [3:0] ST_ALPHA  = 4'd3;
  localparam logic [3:0] ST_MIXM   = 4'd4;
  localparam logic [3:0] ST_MIXF   = 4'd5;
  localparam logic [3:0] ST_STEP   = 4'd6;
  localparam logic [3:0] ST_PA     = 4'd7;
  localparam logic [3:0] ST_PB     = 4'd8;
  localparam logic [3:0] ST_AM     = 4'd9;
  localparam logic [3:0] ST_AF     = 4'd10;
  localparam logic [3:0] ST_BM     = 4'd11;
  localparam logic [3:0] ST_BF     = 4'd12;
  localparam logic [3:0] ST_COMMIT = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic       go_r, go_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      go_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r    <= go_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    go_nxt    = go_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        if (stat.opcode == OP_START || stat.count == 2'd0) begin
          state_nxt = ST_COMMIT;
        end else if (stat.count == 2'd1) begin
          state_nxt = ST_ONE;
        end else begin
          state_nxt = ST_ALPHA;
        end
      end
      ST_ONE, ST_ALPHA, ST_STEP, ST_PA, ST_PB: begin
        case (state_r)
          ST_ONE:   cmd.div_sel = DSEL_ONE;
          ST_ALPHA: cmd.div_sel = DSEL_ALPHA;
          ST_STEP:  cmd.div_sel = DSEL_STEP;
          ST_PA:    cmd.div_sel = DSEL_PA;
          default:  cmd.div_sel = DSEL_PB;
        endcase
        if (!go_r) begin
          cmd.div_go = 1'b1;
          go_nxt     = 1'b1;
        end else if (stat.div_done) begin
          go_nxt = 1'b0;
          case (state_r)
            ST_ONE:   state_nxt = ST_COMMIT;
            ST_ALPHA: state_nxt = ST_MIXM;
            ST_STEP:  state_nxt = ST_PA;
            ST_PA:    state_nxt = ST_PB;
            default:  state_nxt = ST_AM;
          endcase
        end
      end
      ST_MIXM: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MSEL_MIX;
        state_nxt   = ST_MIXF;
      end
      ST_MIXF: begin
        cmd.mul_fin = 1'b1;
        cmd.mul_sel = MSEL_MIX;
        state_nxt   = ST_STEP;
      end
      ST_AM: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MSEL_A;
        state_nxt   = ST_AF;
      end
      ST_AF: begin
        cmd.mul_fin = 1'b1;
        cmd.mul_sel = MSEL_A;
        state_nxt   = ST_BM;
      end
      ST_BM: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MSEL_B;
        state_nxt   = ST_BF;
      end
      ST_BF: begin
        cmd.mul_fin = 1'b1;
        cmd.mul_sel = MSEL_B;
        state_nxt   = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        go_nxt    = 1'b0;
      end
    endcase
  end

endmodule

[rtl/tpsc_dpath.sv]
// Datapath for the crossfade core: slot state, scratch, multiplier, output word.
// Depends on tpsc_pkg and tpsc_div.
module tpsc_dpath import tpsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  tpsc_in_t   in_data,
  input  tpsc_cmd_t  cmd,
  output tpsc_stat_t stat,
  output logic       out_valid,
  input  logic       out_stall,
  output tpsc_out_t  out_data
);

  logic [1:0]        cnt_r;
  logic [ID_W-1:0]   id_r   [2];
  logic [TIME_W-1:0] len_r  [2];
  logic [TIME_W-1:0] tim_r  [2];
  logic [63:0]       tag_r  [2];
  logic [TIME_W-1:0] elap_r;
  logic [TIME_W-1:0] tot_r;

  tpsc_in_t          item_r;
  logic [2:0]        dsel_r;
  logic [16:0]       alpha_r;
  logic [TIME_W-1:0] mix_r;
  logic [15:0]       step_r;
  logic [15:0]       pa_r, pb_r;
  logic [TIME_W-1:0] t0n_r, t1n_r;
  logic [PROD_W-1:0] prod_r;

  logic              out_valid_r;
  tpsc_out_t         out_r;
  tpsc_out_t         out_nxt;

  logic [DVD_W-1:0]  dvd;
  logic [TIME_W-1:0] dvs;
  logic              div_done;
  logic [DVD_W-1:0]  quot;
  logic [TIME_W-1:0] rem;
  logic [TIME_W:0]   sum_one;
  logic [TIME_W-1:0] delta;
  logic [TIME_W-1:0] mul_a;
  logic [16:0]       mul_b;
  logic              b_ge_a;
  logic [TIME_W-1:0] len_diff;
  logic [TIME_W:0]   elap_sum;
  logic              out_free;

  assign delta    = item_r.delta_time[TIME_W-1:0];
  assign sum_one  = {1'b0, tim_r[0]} + {1'b0, delta};
  assign b_ge_a   = len_r[1] >= len_r[0];
  assign len_diff = b_ge_a ? (len_r[1] - len_r[0]) : (len_r[0] - len_r[1]);
  assign elap_sum = {1'b0, elap_r} + {1'b0, delta};
  assign out_free = !out_valid_r || !out_stall;

  // Route divider operands by the requested quotient.
  always_comb begin
    case (cmd.div_sel)
      DSEL_ONE: begin
        dvd = DVD_W'(sum_one);
        dvs = len_r[0];
      end
      DSEL_ALPHA: begin
        dvd = {elap_r, {FRAC_W{1'b0}}};
        dvs = tot_r;
      end
      DSEL_STEP: begin
        dvd = {delta, {FRAC_W{1'b0}}};
        dvs = mix_r;
      end
      DSEL_PA: begin
        dvd = {tim_r[0], {FRAC_W{1'b0}}};
        dvs = len_r[0];
      end
      default: begin
        dvd = {tim_r[1], {FRAC_W{1'b0}}};
        dvs = len_r[1];
      end
    endcase
  end

  tpsc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.div_go),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  always_comb begin
    case (cmd.mul_sel)
      MSEL_MIX: begin
        mul_a = len_diff;
        mul_b = alpha_r;
      end
      MSEL_A: begin
        mul_a = len_r[0];
        mul_b = {1'b0, pa_r};
      end
      default: begin
        mul_a = len_r[1];
        mul_b = {1'b0, pb_r};
      end
    endcase
  end

  // Scratch registers: capture, quotient loads, product and its use.
  always_ff @(posedge clk) begin
    if (cmd.cap) item_r <= in_data;
    if (cmd.div_go) dsel_r <= cmd.div_sel;
    if (div_done) begin
      case (dsel_r)
        DSEL_ONE:   t0n_r <= (len_r[0] == '0) ? '0 : rem;
        DSEL_ALPHA: alpha_r <= (elap_r >= tot_r) ? 17'h10000 : {1'b0, quot[15:0]};
        DSEL_STEP:  step_r <= (mix_r == '0) ? 16'd0 : quot[15:0];
        DSEL_PA:    pa_r <= ((len_r[0] == '0) ? 16'd0 : quot[15:0]) + step_r;
        default:    pb_r <= ((len_r[1] == '0) ? 16'd0 : quot[15:0]) + step_r;
      endcase
    end
    if (cmd.mul_go) prod_r <= PROD_W'({mul_a, 17'd0} >> 17) * PROD_W'(mul_b);
    if (cmd.mul_fin) begin
      case (cmd.mul_sel)
        MSEL_MIX: mix_r <= b_ge_a ? (len_r[0] + prod_r[FRAC_W +: TIME_W])
                                  : (len_r[0] - prod_r[FRAC_W +: TIME_W]);
        MSEL_A:   t0n_r <= prod_r[FRAC_W +: TIME_W];
        default:  t1n_r <= prod_r[FRAC_W +: TIME_W];
      endcase
    end
  end

  // Build the result word from the slot state ahead of this commit.
  always_comb begin
    out_nxt              = '0;
    out_nxt.active_clips = cnt_r;
    out_nxt.first_id     = 16'(id_r[0]);
    out_nxt.first_time   = 32'(tim_r[0]);
    out_nxt.first_tag    = tag_r[0];
    out_nxt.second_id    = 16'(id_r[1]);
    out_nxt.second_time  = 32'(tim_r[1]);
    out_nxt.second_tag   = tag_r[1];
    if (item_r.opcode == OP_START) begin
      out_nxt.accepted = (cnt_r != 2'd2);
      if (cnt_r == 2'd0) begin
        out_nxt.active_clips = 2'd1;
        out_nxt.first_id     = 16'(item_r.clip_id[ID_W-1:0]);
        out_nxt.first_time   = 32'(item_r.start_time[TIME_W-1:0]);
        out_nxt.first_tag    = item_r.tag;
      end else if (cnt_r == 2'd1) begin
        out_nxt.active_clips = 2'd2;
        out_nxt.second_id    = 16'(item_r.clip_id[ID_W-1:0]);
        out_nxt.second_time  = 32'(item_r.start_time[TIME_W-1:0]);
        out_nxt.second_tag   = item_r.tag;
      end
    end else begin
      out_nxt.accepted     = 1'b1;
      out_nxt.sample_valid = (cnt_r != 2'd0);
      out_nxt.mix_alpha    = (cnt_r == 2'd2) ? alpha_r : 17'd0;
      if (cnt_r == 2'd2 && elap_r > tot_r) out_nxt.active_clips = 2'd1;
    end
  end

  // Commit: update slot state and load the output word together.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= 2'd0;
      elap_r      <= '0;
      tot_r       <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 2; k++) begin
        id_r[k]  <= '0;
        len_r[k] <= '0;
        tim_r[k] <= '0;
        tag_r[k] <= '0;
      end
    end else begin
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.commit) begin
        out_r <= out_nxt;
        if (item_r.opcode == OP_START) begin
          if (cnt_r != 2'd2) begin
            id_r[cnt_r[0]]  <= item_r.clip_id[ID_W-1:0];
            len_r[cnt_r[0]] <= item_r.clip_length[TIME_W-1:0];
            tim_r[cnt_r[0]] <= item_r.start_time[TIME_W-1:0];
            tag_r[cnt_r[0]] <= item_r.tag;
            cnt_r           <= cnt_r + 2'd1;
            elap_r          <= '0;
            tot_r           <= item_r.fade_length[TIME_W-1:0];
          end
        end else begin
          if (cnt_r == 2'd1) begin
            tim_r[0] <= t0n_r;
          end else if (cnt_r == 2'd2) begin
            if (elap_r > tot_r) begin
              // Hand slot two over to slot one and empty slot two.
              id_r[0]  <= id_r[1];
              len_r[0] <= len_r[1];
              tim_r[0] <= t1n_r;
              tag_r[0] <= tag_r[1];
              id_r[1]  <= '0;
              len_r[1] <= '0;
              tim_r[1] <= '0;
              tag_r[1] <= '0;
              cnt_r    <= 2'd1;
            end else begin
              tim_r[0] <= t0n_r;
              tim_r[1] <= t1n_r;
              elap_r   <= elap_sum[TIME_W] ? {TIME_W{1'b1}} : elap_sum[TIME_W-1:0];
            end
          end
        end
      end
    end
  end

  assign stat.opcode   = item_r.opcode;
  assign stat.count    = cnt_r;
  assign stat.div_done = div_done;
  assign stat.out_free = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/two_clip_phase_sync_crossfade_core.sv]
// Top level of the two-clip phase-synchronized crossfade core.
// Depends on tpsc_pkg, tpsc_ctrl and tpsc_dpath.
//
// One word in gives one word out. A start word goes from decode straight to
// commit. A tick with one clip takes one modulo; a tick with two clips takes
// alpha, phase step and two phases as four divisions, plus three multiplies.
// Tick time is dominated by the single shared serial divider, which produces
// one quotient bit per cycle over a 48-bit dividend. Words are taken one at a
// time; a finished result sits in the output register and the next word is
// accepted while it waits, but its own result is held until the register
// drains. Tick results show slot contents before the time advance.
module two_clip_phase_sync_crossfade_core import tpsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  tpsc_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output tpsc_out_t out_data
);

  tpsc_cmd_t  cmd;
  tpsc_stat_t stat;

  // Sequence each word through the shared divider and multiplier.
  tpsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold slot state, do the arithmetic, register the result word.
  tpsc_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[dv/tb_two_clip_phase_sync_crossfade_core.sv]
// Testbench for the two-clip phase-synchronized crossfade core.
// Drives start and tick words, predicts each result word and compares by field.
// Depends on tpsc_pkg and two_clip_phase_sync_crossfade_core.
module tb_two_clip_phase_sync_crossfade_core;
  import tpsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM = 2000;
  localparam longint CYCLE_LIMIT = 64'd4000000;
  localparam logic [31:0] TMAX = 32'hFFFF_FFFF;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  tpsc_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  tpsc_out_t out_data;

  two_clip_phase_sync_crossfade_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Predictor's copy of the player state.
  logic [1:0]  pl_count;
  logic [15:0] pl_id[2];
  logic [31:0] pl_len[2];
  logic [31:0] pl_time[2];
  logic [63:0] pl_tag[2];
  logic [31:0] pl_elapsed;
  logic [31:0] pl_total;

  tpsc_out_t expected_words[$];
  int        errors;
  longint    cycles;
  int        send_idle_pct;
  int        recv_stall_pct;

  // Directed words; a row with a typed result has check_row set.
  typedef struct {
    tpsc_in_t  w;
    bit        check_row;
    tpsc_out_t r;
  } dir_row_t;
  dir_row_t dir_rows[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [16:0] blend_weight();
    if (pl_elapsed >= pl_total) return 17'd65536;
    return 17'(({16'd0, pl_elapsed, 16'd0}) / {32'd0, pl_total});
  endfunction

  function automatic logic [15:0] phase_in(logic [31:0] t, logic [31:0] d);
    logic [63:0] q;
    if (d == 0) return 16'd0;
    q = {16'd0, t, 16'd0} / {32'd0, d};
    return q[15:0];
  endfunction

  function automatic void clear_player_slot(int k);
    pl_id[k] = '0; pl_len[k] = '0; pl_time[k] = '0; pl_tag[k] = '0;
  endfunction

  function automatic void reset_player();
    pl_count = 2'd0; clear_player_slot(0); clear_player_slot(1);
    pl_elapsed = '0; pl_total = '0;
  endfunction

  function automatic void show_slots(ref tpsc_out_t o);
    o.active_clips = pl_count;
    o.first_id = pl_id[0];  o.first_time = pl_time[0];  o.first_tag = pl_tag[0];
    o.second_id = pl_id[1]; o.second_time = pl_time[1]; o.second_tag = pl_tag[1];
  endfunction

  // Advance one clip by modulo, or both clips in phase lockstep, then hand over when the fade is done.
  function automatic void advance_clips(logic [31:0] delta);
    logic [16:0] a;
    logic [63:0] mix, stepq, s;
    logic [15:0] step, pa, pb;
    if (pl_count == 1) begin
      pl_time[0] = (pl_len[0] == 0) ? 32'd0
                 : 32'(({32'd0, pl_time[0]} + delta) % {32'd0, pl_len[0]});
    end else if (pl_count == 2) begin
      a = blend_weight();
      if (pl_len[1] >= pl_len[0])
        mix = pl_len[0] + ((64'(pl_len[1] - pl_len[0]) * a) >> 16);
      else
        mix = pl_len[0] - ((64'(pl_len[0] - pl_len[1]) * a) >> 16);
      if (mix == 0) step = 16'd0;
      else begin
        stepq = {16'd0, delta, 16'd0} / mix;
        step = stepq[15:0];
      end
      pa = phase_in(pl_time[0], pl_len[0]) + step;
      pb = phase_in(pl_time[1], pl_len[1]) + step;
      pl_time[0] = 32'((64'(pa) * pl_len[0]) >> 16);
      pl_time[1] = 32'((64'(pb) * pl_len[1]) >> 16);
      if (pl_elapsed > pl_total) begin
        pl_id[0] = pl_id[1]; pl_len[0] = pl_len[1];
        pl_time[0] = pl_time[1]; pl_tag[0] = pl_tag[1];
        clear_player_slot(1);
        pl_count = 2'd1;
      end else begin
        s = 64'(pl_elapsed) + delta;
        pl_elapsed = (s > TMAX) ? TMAX : s[31:0];
      end
    end
  endfunction

  function automatic tpsc_out_t predict_word(tpsc_in_t w);
    tpsc_out_t o;
    int k;
    o = '0;
    if (w.opcode == OP_START) begin
      if (pl_count < 2) begin
        k = (pl_count == 0) ? 0 : 1;
        pl_id[k] = w.clip_id; pl_len[k] = w.clip_length;
        pl_time[k] = w.start_time; pl_tag[k] = w.tag;
        pl_count++;
        pl_elapsed = '0; pl_total = w.fade_length;
        o.accepted = 1'b1;
      end
      show_slots(o);
    end else begin
      o.accepted = 1'b1;
      show_slots(o);
      if (pl_count != 0) begin
        o.sample_valid = 1'b1;
        o.mix_alpha = (pl_count == 2) ? blend_weight() : 17'd0;
      end
      advance_clips(w.delta_time);
      o.active_clips = pl_count;
    end
    return o;
  endfunction

  // Offer one word at the falling edge; hold it until accepted. Valid stays
  // up after the accepting edge until the next word replaces it or it drops.
  task automatic send_word(tpsc_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid at the current falling edge and move to the next one.
  task automatic drop_valid();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_expected(tpsc_in_t w, bit use_row, tpsc_out_t r);
    tpsc_out_t p;
    p = predict_word(w);
    if (use_row && p !== r)
      $error("directed row disagrees with predictor: %h vs %h", r, p);
    expected_words.push_back(use_row ? r : p);
  endtask

  function automatic tpsc_in_t start_word(logic [15:0] id, logic [31:0] len,
      logic [31:0] t0, logic [31:0] fade, logic [63:0] tg);
    tpsc_in_t w;
    w = '0;
    w.opcode = OP_START; w.clip_id = id; w.clip_length = len;
    w.start_time = t0; w.fade_length = fade; w.tag = tg;
    w.delta_time = $urandom;
    return w;
  endfunction

  function automatic tpsc_in_t tick_word(logic [31:0] dt);
    tpsc_in_t w;
    w = start_word(16'($urandom), $urandom, $urandom, $urandom, {$urandom, $urandom});
    w.opcode = OP_TICK; w.delta_time = dt;
    return w;
  endfunction

  function automatic logic [31:0] rand_len();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return TMAX;
      2: return $urandom;
      default: return $urandom_range(32'h0010_0000, 32'h0000_8000);
    endcase
  endfunction

  function automatic logic [31:0] rand_delta();
    case ($urandom_range(7))
      0: return 32'd0;
      1: return TMAX;
      2: return $urandom;
      default: return $urandom_range(32'h0000_2000, 32'h0000_0100);
    endcase
  endfunction

  function automatic void add_row(tpsc_in_t w, bit c, tpsc_out_t r);
    dir_row_t d;
    d.w = w; d.check_row = c; d.r = r;
    dir_rows.push_back(d);
  endfunction

  task automatic drain_results();
    drop_valid();
    while (expected_words.size() != 0) @(negedge clk);
    repeat (250) @(negedge clk);
  endtask

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    tpsc_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word %h", out_data);
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (out_data !== e) begin
          errors++;
          if (out_data.accepted !== e.accepted)
            $error("accepted: exp %h got %h", e.accepted, out_data.accepted);
          if (out_data.sample_valid !== e.sample_valid)
            $error("sample_valid: exp %h got %h", e.sample_valid, out_data.sample_valid);
          if (out_data.active_clips !== e.active_clips)
            $error("active_clips: exp %h got %h", e.active_clips, out_data.active_clips);
          if (out_data.first_id !== e.first_id)
            $error("first_id: exp %h got %h", e.first_id, out_data.first_id);
          if (out_data.first_time !== e.first_time)
            $error("first_time: exp %h got %h", e.first_time, out_data.first_time);
          if (out_data.second_id !== e.second_id)
            $error("second_id: exp %h got %h", e.second_id, out_data.second_id);
          if (out_data.second_time !== e.second_time)
            $error("second_time: exp %h got %h", e.second_time, out_data.second_time);
          if (out_data.mix_alpha !== e.mix_alpha)
            $error("mix_alpha: exp %h got %h", e.mix_alpha, out_data.mix_alpha);
          if (out_data.first_tag !== e.first_tag)
            $error("first_tag: exp %h got %h", e.first_tag, out_data.first_tag);
          if (out_data.second_tag !== e.second_tag)
            $error("second_tag: exp %h got %h", e.second_tag, out_data.second_tag);
        end
      end
    end
  end

  // Receiver: stall at the falling edge according to the current phase.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    tpsc_out_t r;
    tpsc_in_t  w;
    int phase, n, m;
    errors = 0; cycles = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
    rst_n = 1'b0;
    reset_player();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table: typed results only where they are obvious.
    r = '0; r.accepted = 1'b1;
    add_row(tick_word(TMAX), 1, r);                        // tick with no clips
    r = '0; r.accepted = 1'b1; r.active_clips = 2'd1; r.first_id = 16'hFFFF;
    r.first_time = TMAX; r.first_tag = '1;
    add_row(start_word(16'hFFFF, TMAX, TMAX, '0, '1), 1, r); // extremes, first slot
    add_row(tick_word(32'd1), 0, r);                       // one clip, wrap at duration
    add_row(tick_word(TMAX), 0, r);
    add_row(start_word(16'h0000, '0, '0, '0, '0), 0, r);   // zero duration, zero fade
    add_row(tick_word(32'h0001_0000), 0, r);               // alpha one, handover
    add_row(tick_word(32'h0001_0000), 0, r);
    add_row(start_word(16'h1234, 32'h0002_0000, 32'h0005_0000, TMAX, 64'h1), 0, r);
    add_row(start_word(16'h0001, '0, '0, '0, '0), 0, r);   // refused when full
    add_row(tick_word(32'h0000_8000), 0, r);
    add_row(tick_word(TMAX), 0, r);                        // elapsed saturates
    add_row(tick_word(32'd0), 0, r);
    add_row(tick_word(32'h0000_4000), 0, r);
    add_row(start_word(16'h00AA, 32'h0003_0000, '0, 32'h0000_0100, 64'h5), 0, r);
    add_row(start_word(16'h0055, 32'h0001_0000, 32'h0000_8000, 32'h0000_0100, 64'h6),
            0, r);
    for (int i = 0; i < 4; i++) add_row(tick_word(32'h0000_0080), 0, r);
    add_row(start_word(16'h0001, 32'h0001_0000, '0, '0, '0), 0, r);
    add_row(tick_word(32'h0000_0080), 0, r);
    foreach (dir_rows[i]) begin
      push_expected(dir_rows[i].w, dir_rows[i].check_row, dir_rows[i].r);
      send_word(dir_rows[i].w);
    end

    // Random part: mostly start/fade/tick sequences, some noise.
    n = 0;
    while (n < N_RANDOM) begin
      phase = (n / 100) % 4;
      send_idle_pct  = (phase == 1) ? 45 : (phase == 3) ? 17 : 0;
      recv_stall_pct = (phase == 2) ? 45 : (phase == 3) ? 17 : 0;
      if ($urandom_range(9) < 7) begin
        w = start_word(16'($urandom), rand_len(), $urandom_range(32'h0010_0000, 0),
                       ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h4000, 0),
                       {$urandom, $urandom});
        if ($urandom_range(3) == 0) w.start_time = $urandom;
        m = $urandom_range(12, 1);
      end else begin
        w = ($urandom_range(1) == 0) ? tick_word($urandom)
          : start_word(16'($urandom), $urandom, $urandom, $urandom,
                       {$urandom, $urandom});
        m = 0;
      end
      push_expected(w, 0, r);
      send_word(w);
      n++;
      for (int j = 0; j < m && n < N_RANDOM; j++) begin
        w = tick_word(rand_delta());
        push_expected(w, 0, r);
        send_word(w);
        n++;
      end
      // Hold off until every expected word has come back, now and then.
      if (n % 500 < 13) begin
        drop_valid();
        while (expected_words.size() != 0) @(negedge clk);
      end
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain_results();
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
